// ----- rtl/dsc_pkg.sv -----
// ----------------------------------------------------------------------------
// dsc_pkg: shared types, constants and calendar functions
// Calendar tables, seconds constants and the request/result records shared
// by the sequencer and the top level of the seconds converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

  // Request kinds
  localparam logic REQ_TO_SECS = 1'b0;
  localparam logic REQ_TO_CAL  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_MIN_YEAR = 1'b0;
  localparam logic CFG_MAX_YEAR = 1'b1;

  // Reset values of the year window
  localparam logic [6:0] MIN_YEAR_RST = 7'd0;
  localparam logic [6:0] MAX_YEAR_RST = 7'd99;

  // Calendar limits
  localparam logic [3:0] MONTH_FIRST = 4'd1;
  localparam logic [3:0] MONTH_FEB   = 4'd2;
  localparam logic [3:0] MONTH_LAST  = 4'd12;
  localparam logic [4:0] HOUR_MAX    = 5'd23;
  localparam logic [5:0] MINSEC_MAX  = 6'd59;

  // Seconds per unit
  localparam int unsigned DAY_SECS_I = 24 * 60 * 60;
  localparam logic [31:0] DAY_SECS   = 32'(DAY_SECS_I);
  localparam logic [31:0] HOUR_SECS  = 32'(60 * 60);
  localparam logic [31:0] MIN_SECS   = 32'(60);
  localparam logic [31:0] MIN_PER_DAY = 32'(1440);
  localparam logic [31:0] SECS_28D   = 32'(DAY_SECS_I * 28);
  localparam logic [31:0] SECS_29D   = 32'(DAY_SECS_I * 29);
  localparam logic [31:0] SECS_30D   = 32'(DAY_SECS_I * 30);
  localparam logic [31:0] SECS_31D   = 32'(DAY_SECS_I * 31);
  localparam logic [31:0] SECS_365D  = 32'(DAY_SECS_I * 365);
  localparam logic [31:0] SECS_366D  = 32'(DAY_SECS_I * 366);

  typedef struct packed {
    logic        req_type;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] seconds_in;
  } dsc_req_t;

  typedef struct packed {
    logic [31:0] seconds_out;
    logic [6:0]  year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic        valid_res;
  } dsc_res_t;

  // Days in month m; any code outside 1..12 reads as 31
  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
    logic [4:0] days;
    if (m == MONTH_FEB) begin
      days = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      days = 5'd30;
    end else begin
      days = 5'd31;
    end
    return days;
  endfunction

  function automatic logic [8:0] year_days(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [31:0] month_secs(input logic leap, input logic [3:0] m);
    logic [31:0] secs;
    case (month_days(leap, m))
      5'd28:   secs = SECS_28D;
      5'd29:   secs = SECS_29D;
      5'd30:   secs = SECS_30D;
      default: secs = SECS_31D;
    endcase
    return secs;
  endfunction

  function automatic logic [31:0] year_secs(input logic leap);
    return leap ? SECS_366D : SECS_365D;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dsc_alu.sv -----
// ----------------------------------------------------------------------------
// dsc_alu: shared add / compare-subtract unit
// One 33-bit adder serves year/month accumulation and every trial subtraction;
// ge reports a >= b when subtracting.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_alu
  import dsc_pkg::*;
(
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic        sub,
  output logic [31:0]      result,
  output logic             ge
);

  logic [32:0] sum;

  // Two's complement subtract through the same adder
  assign sum    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {32'd0, sub};
  assign result = sum[31:0];
  assign ge     = sub & sum[32];

endmodule

`default_nettype wire

// ----- rtl/dsc_core.sv -----
// ----------------------------------------------------------------------------
// dsc_core: conversion sequencer
// Walks years and months (and, towards calendar, days, hours and minutes) one
// step per cycle through the shared adder, and holds the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_core
  import dsc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire dsc_req_t req_in,
  input  wire logic [6:0] min_year,
  input  wire logic [6:0] max_year,
  output logic          ready,
  output logic          res_valid,
  input  wire logic     res_take,
  output dsc_res_t      result
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_YEAR_ADD  = 4'd2;
  localparam logic [3:0] S_MONTH_ADD = 4'd3;
  localparam logic [3:0] S_SCALE_MIN = 4'd4;
  localparam logic [3:0] S_SCALE_SEC = 4'd5;
  localparam logic [3:0] S_YEAR_SUB  = 4'd6;
  localparam logic [3:0] S_MONTH_SUB = 4'd7;
  localparam logic [3:0] S_DAY_SUB   = 4'd8;
  localparam logic [3:0] S_HOUR_SUB  = 4'd9;
  localparam logic [3:0] S_MIN_SUB   = 4'd10;
  localparam logic [3:0] S_DONE      = 4'd11;

  logic [3:0]  state, state_next;
  logic        req;
  logic        vld;
  logic [31:0] acc;
  logic [7:0]  cnt;
  logic [3:0]  mon;
  logic [6:0]  y_in;
  logic [3:0]  mo_in;
  logic [4:0]  d_in;
  logic [4:0]  dd;
  logic [4:0]  hh;
  logic [5:0]  mm;
  logic [5:0]  ss;

  logic [31:0] alu_b;
  logic        alu_sub;
  logic [31:0] alu_res;
  logic        alu_ge;
  logic        leap_cnt;
  logic        leap_month;
  logic        month_ok;
  logic        in_ok;
  logic        year_past;
  logic        month_hit;

  assign leap_cnt   = (cnt[1:0] == 2'd0);
  assign leap_month = req ? leap_cnt : (y_in[1:0] == 2'd0);
  assign year_past  = (cnt > {1'b0, max_year});
  assign month_hit  = (mon == mo_in);

  // Range checks; month is proven legal before its length counts
  assign month_ok = (mo_in >= MONTH_FIRST) && (mo_in <= MONTH_LAST);
  assign in_ok = (ss <= MINSEC_MAX) && (mm <= MINSEC_MAX) && (hh <= HOUR_MAX) &&
                 month_ok && (d_in != 5'd0) &&
                 (d_in <= month_days(y_in[1:0] == 2'd0, mo_in)) &&
                 (y_in >= min_year) && (y_in <= max_year);

  // Select the operand of the shared unit
  always_comb begin
    alu_b   = 32'd0;
    alu_sub = 1'b0;
    case (state)
      S_YEAR_ADD:  alu_b = 32'(year_days(leap_cnt));
      S_MONTH_ADD: alu_b = month_hit ? 32'(d_in - 5'd1) : 32'(month_days(leap_month, mon));
      S_YEAR_SUB: begin
        alu_b   = year_secs(leap_cnt);
        alu_sub = 1'b1;
      end
      S_MONTH_SUB: begin
        alu_b   = month_secs(leap_month, mon);
        alu_sub = 1'b1;
      end
      S_DAY_SUB: begin
        alu_b   = DAY_SECS;
        alu_sub = 1'b1;
      end
      S_HOUR_SUB: begin
        alu_b   = HOUR_SECS;
        alu_sub = 1'b1;
      end
      S_MIN_SUB: begin
        alu_b   = MIN_SECS;
        alu_sub = 1'b1;
      end
      default: alu_b = 32'd0;
    endcase
  end

  dsc_alu u_alu (
    .a      (acc),
    .b      (alu_b),
    .sub    (alu_sub),
    .result (alu_res),
    .ge     (alu_ge)
  );

  // Sequence the steps
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (req_in.req_type == REQ_TO_CAL) ? S_YEAR_SUB : S_CHECK;
        end
      end
      S_CHECK:     state_next = in_ok ? S_YEAR_ADD : S_DONE;
      S_YEAR_ADD:  if (cnt == {1'b0, y_in}) state_next = S_MONTH_ADD;
      S_MONTH_ADD: if (month_hit) state_next = S_SCALE_MIN;
      S_SCALE_MIN: state_next = S_SCALE_SEC;
      S_SCALE_SEC: state_next = S_DONE;
      S_YEAR_SUB: begin
        if (year_past) begin
          state_next = S_DONE;
        end else if (!alu_ge) begin
          state_next = S_MONTH_SUB;
        end
      end
      S_MONTH_SUB: if (mon == MONTH_LAST || !alu_ge) state_next = S_DAY_SUB;
      S_DAY_SUB:   if (!alu_ge) state_next = S_HOUR_SUB;
      S_HOUR_SUB:  if (!alu_ge) state_next = S_MIN_SUB;
      S_MIN_SUB:   if (!alu_ge) state_next = S_DONE;
      S_DONE:      if (res_take) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          req   <= req_in.req_type;
          vld   <= 1'b0;
          y_in  <= req_in.year;
          mo_in <= req_in.month;
          d_in  <= req_in.day;
          ss    <= req_in.second;
          hh    <= (req_in.req_type == REQ_TO_CAL) ? 5'd0 : req_in.hour;
          mm    <= (req_in.req_type == REQ_TO_CAL) ? 6'd0 : req_in.minute;
          acc   <= req_in.seconds_in;
          cnt   <= 8'd0;
          mon   <= MONTH_FIRST;
          dd    <= 5'd0;
        end
      end
      S_CHECK: begin
        acc <= 32'd0;
        vld <= in_ok;
      end
      S_YEAR_ADD: begin
        if (cnt != {1'b0, y_in}) begin
          acc <= alu_res;
          cnt <= cnt + 8'd1;
        end
      end
      S_MONTH_ADD: begin
        acc <= alu_res;
        if (!month_hit) mon <= mon + 4'd1;
      end
      S_SCALE_MIN: acc <= acc * MIN_PER_DAY + 32'(hh) * MIN_SECS + 32'(mm);
      S_SCALE_SEC: acc <= acc * MIN_SECS + 32'(ss);
      S_YEAR_SUB: begin
        if (!year_past) begin
          if (alu_ge) begin
            acc <= alu_res;
            cnt <= cnt + 8'd1;
          end else begin
            vld <= 1'b1;
          end
        end
      end
      S_MONTH_SUB: begin
        if (mon != MONTH_LAST && alu_ge) begin
          acc <= alu_res;
          mon <= mon + 4'd1;
        end
      end
      S_DAY_SUB: begin
        if (alu_ge) begin
          acc <= alu_res;
          dd  <= dd + 5'd1;
        end
      end
      S_HOUR_SUB: begin
        if (alu_ge) begin
          acc <= alu_res;
          hh  <= hh + 5'd1;
        end
      end
      S_MIN_SUB: begin
        if (alu_ge) begin
          acc <= alu_res;
          mm  <= mm + 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Drive the result; unused fields read zero
  always_comb begin
    result             = '0;
    result.valid_res   = vld;
    if (vld && req == REQ_TO_SECS) begin
      result.seconds_out = acc;
    end
    if (vld && req == REQ_TO_CAL) begin
      result.year_out   = cnt[6:0];
      result.month_out  = mon;
      result.day_out    = dd + 5'd1;
      result.hour_out   = hh;
      result.minute_out = mm;
      result.second_out = acc[5:0];
    end
  end

  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // Checks
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_take |=> res_valid)
    else $error("result dropped before it was taken");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start |=> !ready)
    else $error("sequencer idle right after a start");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && vld && req == REQ_TO_CAL |-> mon >= MONTH_FIRST && mon <= MONTH_LAST)
    else $error("month out of range on a calendar result");

  a_year_window: assert property (@(posedge clk) disable iff (rst)
    res_valid && vld && req == REQ_TO_CAL |-> cnt <= {1'b0, max_year})
    else $error("calendar year beyond the last allowed year");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && vld && req == REQ_TO_CAL |-> hh <= HOUR_MAX && mm <= MINSEC_MAX &&
    acc <= 32'(MINSEC_MAX))
    else $error("time of day out of range on a calendar result");

endmodule

`default_nettype wire

// ----- rtl/datetime_seconds_converter.sv -----
// Sequence: calendar to seconds checks the fields and, if they pass, walks years
//   and months, then scales to seconds; seconds to calendar walks years, months,
//   days, hours and minutes, one step per cycle through the shared adder.
// Throughput: one transaction at a time; a result waits in the output register
//   while the next transaction is already being worked on.
// Reset: synchronous; clears control state and sets min_year to 0, max_year to 99.
// ----------------------------------------------------------------------------
// datetime_seconds_converter: calendar time <-> seconds since 2000
// Stream ports, plain configuration write port and the output register
// in front of the iterative sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module datetime_seconds_converter
  import dsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration
  input  wire logic        cfg_wen,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data,
  // Requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // year[6:0], month[10:7], day[15:11], hour[20:16], minute[26:21],
  // second[32:27], seconds_in[64:33], zero[71:65]
  input  wire logic [71:0] s_axis_tdata,
  // req_type[0]
  input  wire logic [0:0]  s_axis_tuser,
  // Results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // seconds_out[31:0], year_out[38:32], month_out[42:39], day_out[47:43],
  // hour_out[52:48], minute_out[58:53], second_out[64:59], zero[71:65]
  output logic [71:0]      m_axis_tdata,
  // valid_res[0]
  output logic [0:0]       m_axis_tuser
);

  logic [6:0] min_year;
  logic [6:0] max_year;
  dsc_req_t   req;
  dsc_res_t   res;
  logic       core_ready;
  logic       core_valid;
  logic       take;
  logic       start;

  // Write the year window
  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= MIN_YEAR_RST;
      max_year <= MAX_YEAR_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_MIN_YEAR: min_year <= cfg_data;
        CFG_MAX_YEAR: max_year <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Unpack the request
  always_comb begin
    req.req_type   = s_axis_tuser[0];
    req.year       = s_axis_tdata[6:0];
    req.month      = s_axis_tdata[10:7];
    req.day        = s_axis_tdata[15:11];
    req.hour       = s_axis_tdata[20:16];
    req.minute     = s_axis_tdata[26:21];
    req.second     = s_axis_tdata[32:27];
    req.seconds_in = s_axis_tdata[64:33];
  end

  assign s_axis_tready = core_ready;
  assign start         = s_axis_tvalid & core_ready;

  dsc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_in    (req),
    .min_year  (min_year),
    .max_year  (max_year),
    .ready     (core_ready),
    .res_valid (core_valid),
    .res_take  (take),
    .result    (res)
  );

  // Load the output register when it is empty or being drained
  assign take = core_valid & (~m_axis_tvalid | m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= {7'd0, res.second_out, res.minute_out, res.hour_out,
                       res.day_out, res.month_out, res.year_out, res.seconds_out};
      m_axis_tuser <= res.valid_res;
    end
  end

endmodule

`default_nettype wire
